>>> hw/rtl/apsc_pkg.sv
package apsc_pkg;

    localparam int PARAM_SET_BYTES = 64;
    localparam int PS_ADDR_W       = $clog2(PARAM_SET_BYTES);
    localparam int CNT_W           = 7;
    localparam int FPOS_W          = 25;
    localparam int RECENT_W        = 24;
    localparam int LP_W            = 24;
    localparam int HDR_W           = 5;

    localparam logic [FPOS_W-1:0] MAX_FRAME_BYTES = FPOS_W'(25'd16777216);
    localparam logic [RECENT_W-1:0] RECENT_INIT   = '1;

    localparam logic REQ_FRAME = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_RECORD  = 1'b1;

    localparam logic [1:0] OUT_WRITTEN   = 2'd0;
    localparam logic [1:0] OUT_CFG_BUILT = 2'd1;
    localparam logic [1:0] OUT_NO_CFG    = 2'd2;

    localparam logic [HDR_W-1:0] NAL_TYPE_MASK = 5'h1F;
    localparam logic [HDR_W-1:0] NAL_IDR       = 5'h05;
    localparam logic [HDR_W-1:0] NAL_SPS       = 5'h07;
    localparam logic [HDR_W-1:0] NAL_PPS       = 5'h08;

    localparam logic [7:0] START_CODE_END  = 8'h01;
    localparam logic [7:0] AVCC_VERSION    = 8'h01;
    localparam logic [7:0] AVCC_LEN_SIZE   = 8'hFC | 8'h03;
    localparam logic [7:0] AVCC_NUM_SPS    = 8'hE0 | 8'h01;
    localparam logic [7:0] AVCC_NUM_PPS    = 8'h01;
    localparam logic [7:0] AVCC_FIXED_LEN  = 8'd11;

    typedef enum logic [1:0] {
        SEG_NONE = 2'd0,
        SEG_SPS  = 2'd1,
        SEG_PPS  = 2'd2,
        SEG_WAIT = 2'd3
    } seg_kind_t;

    typedef enum logic [1:0] {
        SRC_CONST = 2'd0,
        SRC_SPS   = 2'd1,
        SRC_PPS   = 2'd2
    } rec_src_t;

    typedef struct packed {
        logic [7:0]       record_length;
        logic             record_valid;
        logic [7:0]       record_byte;
        logic             capture_overrun;
        logic [CNT_W-1:0] pps_length;
        logic [CNT_W-1:0] sps_length;
        logic [LP_W-1:0]  length_prefix;
        logic             key_frame;
        logic [1:0]       frame_outcome;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int OUT_W    = 64;

endpackage

>>> hw/rtl/apsc_ram.sv
module apsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/annexb_param_set_capture_unit.sv
// Annex B parameter-set capture. Frame bytes (s_tuser 0) stream in one per cycle while
// s_tready is high; while the SPS or PPS is still missing at frame start, every
// 00 00 00 01 start code inside the frame opens a segment, and NAL units of type 7 or 8
// are written from the header byte onward into two 64-byte RAMs (longer sets are
// truncated and flag overrun). The last byte of a frame (s_tlast) returns one summary
// transaction: outcome, keyframe mark, length prefix and parameter lengths. A read
// request (s_tuser 1) returns one byte of the avcC record at the index in s_tdata[15:8].
// The block takes one transaction per cycle while the output is not stalled; a result
// passes through a capture stage that waits on the registered RAM read and then an
// output register. No clearing pass is needed after reset.
module annexb_param_set_capture_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data_byte[7:0], read_index[15:8]
    input  logic        s_tuser,   // req_type
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // frame_outcome[1:0], key_frame[2], length_prefix[26:3],
                                   // sps_length[33:27], pps_length[40:34],
                                   // capture_overrun[41], record_byte[49:42],
                                   // record_valid[50], record_length[58:51], zeros above
    output logic        m_tuser    // result_kind
);

    localparam logic [apsc_pkg::FPOS_W-1:0] PSB_F =
        apsc_pkg::FPOS_W'(apsc_pkg::PARAM_SET_BYTES);

    logic [apsc_pkg::FPOS_W-1:0]   fpos_reg, fpos_next;
    logic [apsc_pkg::FPOS_W-1:0]   off_reg, off_next;
    logic [apsc_pkg::RECENT_W-1:0] recent_reg, recent_next;
    apsc_pkg::seg_kind_t           kind_reg, kind_next;
    logic                          scan_reg, scan_next;
    logic                          cfg_reg, cfg_next;
    logic [apsc_pkg::HDR_W-1:0]    fht_reg, fht_next;
    logic                          ovr_reg, ovr_next;
    logic [apsc_pkg::CNT_W-1:0]    sps_cnt_reg, sps_cnt_next;
    logic [apsc_pkg::CNT_W-1:0]    pps_cnt_reg, pps_cnt_next;

    logic                          s1_valid_reg, s1_valid_next;
    apsc_pkg::result_t             s1_res_reg, s1_res_next;
    apsc_pkg::rec_src_t            s1_src_reg, s1_src_next;
    logic                          s1_kind_reg, s1_kind_next;
    logic                          s2_valid_reg, s2_valid_next;
    apsc_pkg::result_t             s2_res_reg, s2_res_next;
    logic                          s2_kind_reg, s2_kind_next;

    logic                          s1_adv;
    logic                          accept;
    logic                          frame_acc;
    logic                          read_acc;
    logic [7:0]                    b;
    logic [7:0]                    ridx;

    logic                          frame_start;
    logic                          scan_eff;
    logic                          in_range;
    apsc_pkg::seg_kind_t           kind_eff, kind1;
    logic [apsc_pkg::FPOS_W-1:0]   off_eff;
    logic [apsc_pkg::RECENT_W-1:0] recent_eff;
    logic [apsc_pkg::HDR_W-1:0]    fht_eff;
    logic [apsc_pkg::HDR_W-1:0]    hdr_type;
    logic [apsc_pkg::FPOS_W-1:0]   wr_idx;
    logic                          wr_ok;
    logic                          sc_hit;
    logic [apsc_pkg::FPOS_W-1:0]   fpos_new;
    logic                          cl_en;
    apsc_pkg::seg_kind_t           cl_kind;
    logic [apsc_pkg::FPOS_W-1:0]   cl_end, cl_off, cl_len;
    logic [apsc_pkg::CNT_W-1:0]    cl_cnt;

    logic                          sps_we, pps_we;
    logic [apsc_pkg::PS_ADDR_W-1:0] wr_addr;
    logic [apsc_pkg::PS_ADDR_W-1:0] sps_raddr, pps_raddr;
    logic [7:0]                    sps_rd, pps_rd;

    logic [7:0]                    s8, p8, rlen;
    logic                          rvalid;
    apsc_pkg::rec_src_t            rsrc;
    logic [7:0]                    rconst;
    logic [7:0]                    sps_ridx, pps_ridx;

    assign s1_adv    = !s2_valid_reg || m_tready;
    assign s_tready  = !s1_valid_reg || s1_adv;
    assign accept    = s_tvalid && s_tready;
    assign frame_acc = accept && (s_tuser == apsc_pkg::REQ_FRAME);
    assign read_acc  = accept && (s_tuser == apsc_pkg::REQ_READ);
    assign b         = s_tdata[7:0];
    assign ridx      = s_tdata[15:8];

    // frame byte path
    always_comb
    begin
        frame_start = (fpos_reg == '0);
        scan_eff    = frame_start ? ((sps_cnt_reg == '0) || (pps_cnt_reg == '0)) : scan_reg;
        kind_eff    = frame_start ? apsc_pkg::SEG_NONE : kind_reg;
        off_eff     = frame_start ? '0 : off_reg;
        recent_eff  = frame_start ? apsc_pkg::RECENT_INIT : recent_reg;
        fht_eff     = frame_start ? '0 : fht_reg;
        in_range    = (fpos_reg < apsc_pkg::MAX_FRAME_BYTES);
        hdr_type    = b[apsc_pkg::HDR_W-1:0] & apsc_pkg::NAL_TYPE_MASK;

        kind1 = kind_eff;
        if (scan_eff && in_range && (kind_eff == apsc_pkg::SEG_WAIT) && (fpos_reg == off_eff))
        begin
            if (hdr_type == apsc_pkg::NAL_SPS)
            begin
                kind1 = apsc_pkg::SEG_SPS;
            end
            else if (hdr_type == apsc_pkg::NAL_PPS)
            begin
                kind1 = apsc_pkg::SEG_PPS;
            end
            else
            begin
                kind1 = apsc_pkg::SEG_NONE;
            end
        end

        wr_idx  = fpos_reg - off_eff;
        wr_ok   = scan_eff && in_range && (fpos_reg >= off_eff) && (wr_idx < PSB_F);
        wr_addr = wr_idx[apsc_pkg::PS_ADDR_W-1:0];
        sps_we  = frame_acc && wr_ok && (kind1 == apsc_pkg::SEG_SPS);
        pps_we  = frame_acc && wr_ok && (kind1 == apsc_pkg::SEG_PPS);

        sc_hit = scan_eff && in_range && (recent_eff == '0) &&
                 (b == apsc_pkg::START_CODE_END) && (fpos_reg >= apsc_pkg::FPOS_W'(3));

        fpos_new = in_range ? fpos_reg + apsc_pkg::FPOS_W'(1) : fpos_reg;

        kind_next   = kind1;
        off_next    = off_eff;
        if (sc_hit)
        begin
            kind_next = apsc_pkg::SEG_WAIT;
            off_next  = fpos_reg + apsc_pkg::FPOS_W'(1);
        end
        recent_next = in_range ? {recent_eff[apsc_pkg::RECENT_W-9:0], b} : recent_eff;
        fht_next    = (in_range && (fpos_reg == apsc_pkg::FPOS_W'(4))) ? hdr_type : fht_eff;
        scan_next   = scan_eff;
        fpos_next   = fpos_new;

        // one segment close at most per byte
        cl_en   = sc_hit || (s_tlast && scan_eff);
        cl_kind = sc_hit ? kind1 : kind_next;
        cl_end  = sc_hit ? fpos_reg - apsc_pkg::FPOS_W'(3) : fpos_new;
        cl_off  = off_eff;
        cl_len  = (cl_end > cl_off) ? cl_end - cl_off : '0;
        cl_cnt  = (cl_len > PSB_F) ? apsc_pkg::CNT_W'(apsc_pkg::PARAM_SET_BYTES)
                                   : cl_len[apsc_pkg::CNT_W-1:0];

        sps_cnt_next = sps_cnt_reg;
        pps_cnt_next = pps_cnt_reg;
        ovr_next     = ovr_reg;
        if (cl_en && ((cl_kind == apsc_pkg::SEG_SPS) || (cl_kind == apsc_pkg::SEG_PPS)))
        begin
            if (cl_len > PSB_F)
            begin
                ovr_next = 1'b1;
            end
            if (cl_kind == apsc_pkg::SEG_SPS)
            begin
                sps_cnt_next = cl_cnt;
            end
            else
            begin
                pps_cnt_next = cl_cnt;
            end
        end

        cfg_next = cfg_reg;
        if (s_tlast)
        begin
            fpos_next = '0;
            scan_next = 1'b0;
            kind_next = apsc_pkg::SEG_NONE;
            off_next  = '0;
            recent_next = apsc_pkg::RECENT_INIT;
            if (!cfg_reg && (sps_cnt_next != '0) && (pps_cnt_next != '0))
            begin
                cfg_next = 1'b1;
            end
        end
    end

    // avcC record read path
    always_comb
    begin
        s8       = {1'b0, sps_cnt_reg};
        p8       = {1'b0, pps_cnt_reg};
        rlen     = apsc_pkg::AVCC_FIXED_LEN + s8 + p8;
        rvalid   = cfg_reg && (ridx < rlen);
        sps_ridx = (ridx <= 8'd3) ? ridx : ridx - 8'd8;
        pps_ridx = ridx - apsc_pkg::AVCC_FIXED_LEN - s8;
        sps_raddr = sps_ridx[apsc_pkg::PS_ADDR_W-1:0];
        pps_raddr = pps_ridx[apsc_pkg::PS_ADDR_W-1:0];
        rsrc     = apsc_pkg::SRC_CONST;
        rconst   = 8'h00;
        if (!rvalid)
        begin
            rconst = 8'h00;
        end
        else if (ridx == 8'd0)
        begin
            rconst = apsc_pkg::AVCC_VERSION;
        end
        else if (ridx <= 8'd3)
        begin
            if (ridx < s8)
            begin
                rsrc = apsc_pkg::SRC_SPS;
            end
        end
        else if (ridx == 8'd4)
        begin
            rconst = apsc_pkg::AVCC_LEN_SIZE;
        end
        else if (ridx == 8'd5)
        begin
            rconst = apsc_pkg::AVCC_NUM_SPS;
        end
        else if (ridx == 8'd6)
        begin
            rconst = 8'h00;
        end
        else if (ridx == 8'd7)
        begin
            rconst = s8;
        end
        else if (ridx < 8'd8 + s8)
        begin
            rsrc = apsc_pkg::SRC_SPS;
        end
        else if (ridx == 8'd8 + s8)
        begin
            rconst = apsc_pkg::AVCC_NUM_PPS;
        end
        else if (ridx == 8'd9 + s8)
        begin
            rconst = 8'h00;
        end
        else if (ridx == 8'd10 + s8)
        begin
            rconst = p8;
        end
        else
        begin
            rsrc = apsc_pkg::SRC_PPS;
        end
    end

    // capture stage and output register
    always_comb
    begin
        s1_res_next  = '0;
        s1_src_next  = apsc_pkg::SRC_CONST;
        s1_kind_next = apsc_pkg::KIND_SUMMARY;
        if (read_acc)
        begin
            s1_kind_next                = apsc_pkg::KIND_RECORD;
            s1_src_next                 = rsrc;
            s1_res_next.sps_length      = sps_cnt_reg;
            s1_res_next.pps_length      = pps_cnt_reg;
            s1_res_next.capture_overrun = ovr_reg;
            s1_res_next.record_byte     = rconst;
            s1_res_next.record_valid    = rvalid;
            s1_res_next.record_length   = cfg_reg ? rlen : 8'h00;
        end
        else
        begin
            if (cfg_reg)
            begin
                s1_res_next.frame_outcome = apsc_pkg::OUT_WRITTEN;
            end
            else if (cfg_next)
            begin
                s1_res_next.frame_outcome = apsc_pkg::OUT_CFG_BUILT;
            end
            else
            begin
                s1_res_next.frame_outcome = apsc_pkg::OUT_NO_CFG;
            end
            s1_res_next.key_frame       = (fpos_new > apsc_pkg::FPOS_W'(4)) &&
                                          (fht_next == apsc_pkg::NAL_IDR);
            s1_res_next.length_prefix   = (fpos_new >= apsc_pkg::FPOS_W'(4)) ?
                                          apsc_pkg::LP_W'(fpos_new - apsc_pkg::FPOS_W'(4)) :
                                          '0;
            s1_res_next.sps_length      = sps_cnt_next;
            s1_res_next.pps_length      = pps_cnt_next;
            s1_res_next.capture_overrun = ovr_next;
        end

        if (read_acc || (frame_acc && s_tlast))
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        s2_valid_next = s1_adv ? s1_valid_reg : s2_valid_reg;
        s2_kind_next  = s1_kind_reg;
        s2_res_next   = s1_res_reg;
        case (s1_src_reg)
            apsc_pkg::SRC_SPS: s2_res_next.record_byte = sps_rd;
            apsc_pkg::SRC_PPS: s2_res_next.record_byte = pps_rd;
            default:           s2_res_next.record_byte = s1_res_reg.record_byte;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fpos_reg     <= '0;
            off_reg      <= '0;
            recent_reg   <= apsc_pkg::RECENT_INIT;
            kind_reg     <= apsc_pkg::SEG_NONE;
            scan_reg     <= 1'b0;
            cfg_reg      <= 1'b0;
            fht_reg      <= '0;
            ovr_reg      <= 1'b0;
            sps_cnt_reg  <= '0;
            pps_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (frame_acc)
            begin
                fpos_reg    <= fpos_next;
                off_reg     <= off_next;
                recent_reg  <= recent_next;
                kind_reg    <= kind_next;
                scan_reg    <= scan_next;
                cfg_reg     <= cfg_next;
                fht_reg     <= fht_next;
                ovr_reg     <= ovr_next;
                sps_cnt_reg <= sps_cnt_next;
                pps_cnt_reg <= pps_cnt_next;
            end
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg  <= s1_res_next;
            s1_src_reg  <= s1_src_next;
            s1_kind_reg <= s1_kind_next;
        end
        if (s1_adv && s1_valid_reg)
        begin
            s2_res_reg  <= s2_res_next;
            s2_kind_reg <= s2_kind_next;
        end
    end

    apsc_ram #(
        .WIDTH(8),
        .DEPTH(apsc_pkg::PARAM_SET_BYTES)
    ) u_sps_ram (
        .clk    (clk),
        .wr_en  (sps_we),
        .wr_addr(wr_addr),
        .wr_data(b),
        .rd_en  (read_acc),
        .rd_addr(sps_raddr),
        .rd_data(sps_rd)
    );

    apsc_ram #(
        .WIDTH(8),
        .DEPTH(apsc_pkg::PARAM_SET_BYTES)
    ) u_pps_ram (
        .clk    (clk),
        .wr_en  (pps_we),
        .wr_addr(wr_addr),
        .wr_data(b),
        .rd_en  (read_acc),
        .rd_addr(pps_raddr),
        .rd_data(pps_rd)
    );

    assign m_tvalid = s2_valid_reg;
    assign m_tuser  = s2_kind_reg;
    assign m_tdata  = {{(apsc_pkg::OUT_W - apsc_pkg::RESULT_W){1'b0}}, s2_res_reg};

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int ITEM_TARGET = 1600;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 8;
    localparam int READ_PCT    = 10;

    typedef enum {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;
    typedef enum {SHAPE_SPS, SHAPE_NOISE, SHAPE_TAIL_CODE, SHAPE_SPLIT} shape_t;

    typedef struct packed {
        logic              kind;
        apsc_pkg::result_t r;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;

    int idle_pct    = 0;
    int stall_pct   = 0;
    int items_sent  = 0;
    int errors      = 0;
    int cycle_count = 0;

    // capture tracking state
    logic [7:0]                    sps_mem [apsc_pkg::PARAM_SET_BYTES];
    logic [7:0]                    pps_mem [apsc_pkg::PARAM_SET_BYTES];
    int                            sps_len   = 0;
    int                            pps_len   = 0;
    logic [apsc_pkg::RECENT_W-1:0] win       = apsc_pkg::RECENT_INIT;
    int                            fpos      = 0;
    int                            seg_start = 0;
    apsc_pkg::seg_kind_t           seg_kind  = apsc_pkg::SEG_NONE;
    logic                          scanning  = 1'b0;
    logic                          cfg_built = 1'b0;
    logic [apsc_pkg::HDR_W-1:0]    hdr_type  = '0;
    logic                          ovf_flag  = 1'b0;

    reply_t            reply_q [$];
    logic [7:0]        frame_q [$];
    reply_t            want;
    apsc_pkg::result_t got;

    annexb_param_set_capture_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (reply_q.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, got kind %0d data %0h",
                         $time, m_tuser, m_tdata);
                errors++;
            end
            else
            begin
                want = reply_q.pop_front();
                got  = apsc_pkg::result_t'(m_tdata[apsc_pkg::RESULT_W-1:0]);
                check_field("result_kind", want.kind, m_tuser);
                check_field("frame_outcome", want.r.frame_outcome, got.frame_outcome);
                check_field("key_frame", want.r.key_frame, got.key_frame);
                check_field("length_prefix", want.r.length_prefix, got.length_prefix);
                check_field("sps_length", want.r.sps_length, got.sps_length);
                check_field("pps_length", want.r.pps_length, got.pps_length);
                check_field("capture_overrun", want.r.capture_overrun, got.capture_overrun);
                check_field("record_byte", want.r.record_byte, got.record_byte);
                check_field("record_valid", want.r.record_valid, got.record_valid);
                check_field("record_length", want.r.record_length, got.record_length);
                check_field("tdata_pad", 0, m_tdata[apsc_pkg::OUT_W-1:apsc_pkg::RESULT_W]);
            end
        end
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic close_segment(input int stop_pos);
        int span;
        span = (stop_pos > seg_start) ? stop_pos - seg_start : 0;
        if (seg_kind != apsc_pkg::SEG_SPS && seg_kind != apsc_pkg::SEG_PPS)
            return;
        if (span > apsc_pkg::PARAM_SET_BYTES)
        begin
            span     = apsc_pkg::PARAM_SET_BYTES;
            ovf_flag = 1'b1;
        end
        if (seg_kind == apsc_pkg::SEG_SPS)
            sps_len = span;
        else
            pps_len = span;
    endtask

    task automatic track_annexb_item(input logic req, input logic [7:0] b, input logic lst,
                                     input logic [7:0] ridx);
        reply_t                     rp;
        int                         rlen;
        int                         i;
        int                         slot;
        logic [apsc_pkg::HDR_W-1:0] t;
        rp = '0;
        rp.r.sps_length      = apsc_pkg::CNT_W'(sps_len);
        rp.r.pps_length      = apsc_pkg::CNT_W'(pps_len);
        rp.r.capture_overrun = ovf_flag;
        if (req == apsc_pkg::REQ_READ)
        begin
            rp.kind = apsc_pkg::KIND_RECORD;
            rlen    = int'(apsc_pkg::AVCC_FIXED_LEN) + sps_len + pps_len;
            i       = int'(ridx);
            if (cfg_built)
            begin
                rp.r.record_length = 8'(rlen);
                if (i < rlen)
                begin
                    rp.r.record_valid = 1'b1;
                    if (i == 0)
                        rp.r.record_byte = apsc_pkg::AVCC_VERSION;
                    else if (i <= 3)
                        rp.r.record_byte = (i < sps_len) ? sps_mem[i] : 8'h00;
                    else if (i == 4)
                        rp.r.record_byte = apsc_pkg::AVCC_LEN_SIZE;
                    else if (i == 5)
                        rp.r.record_byte = apsc_pkg::AVCC_NUM_SPS;
                    else if (i == 6)
                        rp.r.record_byte = 8'(sps_len >> 8);
                    else if (i == 7)
                        rp.r.record_byte = 8'(sps_len);
                    else if (i < 8 + sps_len)
                        rp.r.record_byte = sps_mem[i - 8];
                    else if (i == 8 + sps_len)
                        rp.r.record_byte = apsc_pkg::AVCC_NUM_PPS;
                    else if (i == 9 + sps_len)
                        rp.r.record_byte = 8'(pps_len >> 8);
                    else if (i == 10 + sps_len)
                        rp.r.record_byte = 8'(pps_len);
                    else
                        rp.r.record_byte = pps_mem[i - 11 - sps_len];
                end
            end
            reply_q.push_back(rp);
            return;
        end

        if (fpos == 0)
        begin
            scanning  = (sps_len == 0 || pps_len == 0);
            win       = apsc_pkg::RECENT_INIT;
            seg_kind  = apsc_pkg::SEG_NONE;
            seg_start = 0;
            hdr_type  = '0;
        end
        if (fpos < int'(apsc_pkg::MAX_FRAME_BYTES))
        begin
            if (fpos == 4)
                hdr_type = b[apsc_pkg::HDR_W-1:0] & apsc_pkg::NAL_TYPE_MASK;
            if (scanning)
            begin
                if (seg_kind == apsc_pkg::SEG_WAIT && fpos == seg_start)
                begin
                    t = b[apsc_pkg::HDR_W-1:0] & apsc_pkg::NAL_TYPE_MASK;
                    seg_kind = (t == apsc_pkg::NAL_SPS) ? apsc_pkg::SEG_SPS :
                               (t == apsc_pkg::NAL_PPS) ? apsc_pkg::SEG_PPS :
                               apsc_pkg::SEG_NONE;
                end
                slot = fpos - seg_start;
                if ((seg_kind == apsc_pkg::SEG_SPS || seg_kind == apsc_pkg::SEG_PPS)
                    && slot >= 0 && slot < apsc_pkg::PARAM_SET_BYTES)
                begin
                    if (seg_kind == apsc_pkg::SEG_SPS)
                        sps_mem[slot] = b;
                    else
                        pps_mem[slot] = b;
                end
                if (win == '0 && b == apsc_pkg::START_CODE_END && fpos >= 3)
                begin
                    close_segment(fpos - 3);
                    seg_kind  = apsc_pkg::SEG_WAIT;
                    seg_start = fpos + 1;
                end
            end
            win = {win[apsc_pkg::RECENT_W-9:0], b};
            fpos++;
        end
        if (!lst)
            return;

        if (scanning)
            close_segment(fpos);
        rp.kind = apsc_pkg::KIND_SUMMARY;
        if (!cfg_built && sps_len > 0 && pps_len > 0)
        begin
            cfg_built          = 1'b1;
            rp.r.frame_outcome = apsc_pkg::OUT_CFG_BUILT;
        end
        else if (!cfg_built)
            rp.r.frame_outcome = apsc_pkg::OUT_NO_CFG;
        else
            rp.r.frame_outcome = apsc_pkg::OUT_WRITTEN;
        rp.r.key_frame       = (fpos > 4 && hdr_type == apsc_pkg::NAL_IDR);
        rp.r.length_prefix   = (fpos >= 4) ? apsc_pkg::LP_W'(fpos - 4) : '0;
        rp.r.sps_length      = apsc_pkg::CNT_W'(sps_len);
        rp.r.pps_length      = apsc_pkg::CNT_W'(pps_len);
        rp.r.capture_overrun = ovf_flag;
        reply_q.push_back(rp);
        fpos      = 0;
        seg_kind  = apsc_pkg::SEG_NONE;
        seg_start = 0;
        win       = apsc_pkg::RECENT_INIT;
        scanning  = 1'b0;
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            IDLE_SRC:
            begin
                idle_pct  = 83;
                stall_pct = 0;
            end
            IDLE_SNK:
            begin
                idle_pct  = 0;
                stall_pct = 83;
            end
            default:
            begin
                idle_pct  = 36;
                stall_pct = 36;
            end
        endcase
    endtask

    task automatic send_item(input logic req, input logic [7:0] b, input logic lst,
                             input logic [7:0] ridx);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {ridx, b};
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        track_annexb_item(req, b, lst, ridx);
        items_sent++;
    endtask

    task automatic send_read();
        int top;
        top = int'(apsc_pkg::AVCC_FIXED_LEN) + sps_len + pps_len + 4;
        if ($urandom_range(99) < 70)
            send_item(apsc_pkg::REQ_READ, 8'($urandom), 1'($urandom),
                      8'($urandom_range(top)));
        else
            send_item(apsc_pkg::REQ_READ, 8'($urandom), 1'($urandom), 8'($urandom));
    endtask

    task automatic send_frame(input int read_pct);
        int n;
        n = frame_q.size();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < read_pct)
                send_read();
            send_item(apsc_pkg::REQ_FRAME, frame_q[i], i == n - 1, 8'($urandom));
        end
        frame_q.delete();
    endtask

    function automatic logic [apsc_pkg::HDR_W-1:0] junk_type();
        logic [apsc_pkg::HDR_W-1:0] t;
        t = apsc_pkg::HDR_W'($urandom);
        while (t == apsc_pkg::NAL_SPS || t == apsc_pkg::NAL_PPS)
            t = apsc_pkg::HDR_W'($urandom);
        return t;
    endfunction

    task automatic add_nal(input logic [apsc_pkg::HDR_W-1:0] typ, input int nbytes);
        frame_q.push_back(8'h00);
        frame_q.push_back(8'h00);
        frame_q.push_back(8'h00);
        frame_q.push_back(apsc_pkg::START_CODE_END);
        frame_q.push_back({3'($urandom), typ});
        repeat (nbytes - 1)
            frame_q.push_back(($urandom_range(7) == 0) ? 8'h00 : 8'($urandom));
    endtask

    task automatic add_noise(input int n);
        repeat (n)
            frame_q.push_back(8'($urandom));
    endtask

    task automatic test_reads_before_build();
        send_item(apsc_pkg::REQ_READ, 8'hFF, 1'b1, 8'h00);
        send_item(apsc_pkg::REQ_READ, 8'h00, 1'b0, 8'hFF);
    endtask

    task automatic test_short_frames();
        frame_q = '{8'hFF};
        send_frame(0);
        frame_q = '{8'h12, 8'h00, 8'hAB};
        send_frame(0);
        // start code on the last byte: no header follows
        frame_q = '{8'h00, 8'h00, 8'h00, 8'h01};
        send_frame(0);
        frame_q = '{8'h00, 8'h00, 8'h00, 8'h01, 8'hE5};
        send_frame(0);
    endtask

    task automatic test_split_start_code();
        frame_q = '{8'h7F, 8'h00, 8'h00, 8'h00};
        send_frame(0);
        frame_q = '{8'h01, 8'h67, 8'h42, 8'h80};
        send_frame(0);
    endtask

    task automatic test_long_param_set();
        add_nal(apsc_pkg::NAL_SPS, $urandom_range(65, 80));
        send_frame(0);
    endtask

    task automatic test_random_capture();
        int     nframes;
        shape_t shape;
        nframes = $urandom_range(6, 12);
        for (int f = 0; f < nframes; f++)
        begin
            set_idling(idle_mode_t'(f % 4));
            shape = shape_t'($urandom_range(3));
            case (shape)
                SHAPE_SPS:
                begin
                    if ($urandom_range(1))
                        add_nal(junk_type(), $urandom_range(1, 12));
                    add_nal(apsc_pkg::NAL_SPS, $urandom_range(1, 80));
                    if ($urandom_range(1))
                        add_nal(junk_type(), $urandom_range(1, 12));
                end
                SHAPE_NOISE:
                    add_noise($urandom_range(1, 24));
                SHAPE_TAIL_CODE:
                begin
                    add_nal(junk_type(), $urandom_range(1, 12));
                    frame_q.push_back(8'h00);
                    frame_q.push_back(8'h00);
                    if ($urandom_range(1))
                        frame_q.push_back(8'h00);
                    frame_q.push_back(apsc_pkg::START_CODE_END);
                end
                default:
                begin
                    add_noise($urandom_range(0, 6));
                    frame_q.push_back(8'h00);
                    frame_q.push_back(8'h00);
                    frame_q.push_back(8'h00);
                    send_frame(READ_PCT);
                    frame_q.push_back(apsc_pkg::START_CODE_END);
                    frame_q.push_back({3'($urandom), apsc_pkg::NAL_PPS});
                    add_noise($urandom_range(1, 6));
                end
            endcase
            send_frame(READ_PCT);
        end
    endtask

    task automatic test_config_build();
        set_idling(IDLE_BOTH);
        if ($urandom_range(1))
            add_nal(apsc_pkg::NAL_SPS, $urandom_range(1, 3));
        else
            add_nal(apsc_pkg::NAL_SPS, $urandom_range(4, 70));
        if ($urandom_range(1))
            add_nal(junk_type(), $urandom_range(1, 8));
        add_nal(apsc_pkg::NAL_PPS, $urandom_range(1, 70));
        if ($urandom_range(1))
            add_nal(junk_type(), $urandom_range(1, 8));
        send_frame(READ_PCT);
    endtask

    task automatic test_record_sweep();
        int rlen;
        set_idling(IDLE_SNK);
        rlen = int'(apsc_pkg::AVCC_FIXED_LEN) + sps_len + pps_len;
        for (int i = 0; i <= rlen + 1; i++)
            send_item(apsc_pkg::REQ_READ, 8'($urandom), 1'($urandom), 8'(i));
        send_item(apsc_pkg::REQ_READ, 8'($urandom), 1'($urandom), 8'hFF);
    endtask

    task automatic test_random_traffic();
        int roll;
        int n;
        while (items_sent < ITEM_TARGET)
        begin
            set_idling(idle_mode_t'((items_sent / 100) % 4));
            roll = $urandom_range(99);
            if (roll < 20)
            begin
                repeat ($urandom_range(1, 4))
                    send_read();
            end
            else if (roll < 30)
            begin
                add_noise($urandom_range(1, 4));
                send_frame(READ_PCT);
            end
            else
            begin
                n = ($urandom_range(99) < 5) ? $urandom_range(200, 400) : $urandom_range(1, 40);
                if ($urandom_range(3) == 0)
                    add_nal(junk_type(), $urandom_range(1, 6));
                add_nal($urandom_range(1) ? apsc_pkg::NAL_IDR : junk_type(), n);
                send_frame(READ_PCT);
            end
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = apsc_pkg::REQ_FRAME;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        set_idling(IDLE_NONE);
        test_reads_before_build();
        test_short_frames();
        test_split_start_code();
        test_long_param_set();
        test_random_capture();
        test_config_build();
        test_record_sweep();
        test_random_traffic();

        s_tvalid <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
